// File: hw/rtl/tkn_pkg.sv
// Types, keyword table and character helpers for the assembly tokenizer.
package tkn_pkg;

  localparam int NumKeywords = 214;
  localparam logic [7:0] QwordCode = 8'd206;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ZERO,
    MODE_DEC,
    MODE_HEX,
    MODE_BIN,
    MODE_WORD
  } mode_e;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_HEX,
    BASE_BIN
  } base_e;

  typedef enum logic [3:0] {
    TK_NUMBER   = 4'd0,
    TK_IDENT    = 4'd1,
    TK_KEYWORD  = 4'd2,
    TK_COMMA    = 4'd3,
    TK_LBRACKET = 4'd4,
    TK_RBRACKET = 4'd5,
    TK_LBRACE   = 4'd6,
    TK_RBRACE   = 4'd7,
    TK_PLUS     = 4'd8,
    TK_MINUS    = 4'd9,
    TK_STAR     = 4'd10,
    TK_DOLLAR   = 4'd11,
    TK_NEWLINE  = 4'd12,
    TK_EOF      = 4'd13,
    TK_ERROR    = 4'd14
  } kind_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
    logic       force_word;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  code;
    logic [63:0] value;
    logic [63:0] chars;
    logic [7:0]  length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } kw_match_t;

  localparam logic [47:0] KwTable [NumKeywords] = '{
    48'("cr0"), 48'("cr1"), 48'("cr2"), 48'("cr3"), 48'("cr4"), 48'("cr8"),
    48'("dr0"), 48'("dr1"), 48'("dr2"), 48'("dr3"), 48'("dr4"), 48'("dr5"),
    48'("dr6"), 48'("dr7"),
    48'("k1"), 48'("k2"), 48'("k3"), 48'("k4"), 48'("k5"), 48'("k6"), 48'("k7"),
    48'("es"), 48'("cs"), 48'("ss"), 48'("ds"), 48'("fs"), 48'("gs"),
    48'("st0"), 48'("st1"), 48'("st2"), 48'("st3"), 48'("st4"), 48'("st5"),
    48'("st6"), 48'("st7"),
    48'("bnd0"), 48'("bnd1"), 48'("bnd2"), 48'("bnd3"),
    48'("tmm0"), 48'("tmm1"), 48'("tmm2"), 48'("tmm3"), 48'("tmm4"), 48'("tmm5"),
    48'("tmm6"), 48'("tmm7"),
    48'("mm0"), 48'("mm1"), 48'("mm2"), 48'("mm3"), 48'("mm4"), 48'("mm5"),
    48'("mm6"), 48'("mm7"),
    48'("zmm0"), 48'("zmm1"), 48'("zmm2"), 48'("zmm3"), 48'("zmm4"), 48'("zmm5"),
    48'("zmm6"), 48'("zmm7"), 48'("zmm8"), 48'("zmm9"), 48'("zmm10"), 48'("zmm11"),
    48'("zmm12"), 48'("zmm13"), 48'("zmm14"), 48'("zmm15"), 48'("zmm16"),
    48'("zmm17"), 48'("zmm18"), 48'("zmm19"), 48'("zmm20"), 48'("zmm21"),
    48'("zmm22"), 48'("zmm23"), 48'("zmm24"), 48'("zmm25"), 48'("zmm26"),
    48'("zmm27"), 48'("zmm28"), 48'("zmm29"), 48'("zmm30"), 48'("zmm31"),
    48'("ymm0"), 48'("ymm1"), 48'("ymm2"), 48'("ymm3"), 48'("ymm4"), 48'("ymm5"),
    48'("ymm6"), 48'("ymm7"), 48'("ymm8"), 48'("ymm9"), 48'("ymm10"), 48'("ymm11"),
    48'("ymm12"), 48'("ymm13"), 48'("ymm14"), 48'("ymm15"), 48'("ymm16"),
    48'("ymm17"), 48'("ymm18"), 48'("ymm19"), 48'("ymm20"), 48'("ymm21"),
    48'("ymm22"), 48'("ymm23"), 48'("ymm24"), 48'("ymm25"), 48'("ymm26"),
    48'("ymm27"), 48'("ymm28"), 48'("ymm29"), 48'("ymm30"), 48'("ymm31"),
    48'("xmm0"), 48'("xmm1"), 48'("xmm2"), 48'("xmm3"), 48'("xmm4"), 48'("xmm5"),
    48'("xmm6"), 48'("xmm7"), 48'("xmm8"), 48'("xmm9"), 48'("xmm10"), 48'("xmm11"),
    48'("xmm12"), 48'("xmm13"), 48'("xmm14"), 48'("xmm15"),
    48'("rax"), 48'("rcx"), 48'("rdx"), 48'("rbx"), 48'("rsp"), 48'("rbp"),
    48'("rsi"), 48'("rdi"),
    48'("r8"), 48'("r9"), 48'("r10"), 48'("r11"), 48'("r12"), 48'("r13"),
    48'("r14"), 48'("r15"),
    48'("eax"), 48'("ecx"), 48'("edx"), 48'("ebx"), 48'("esp"), 48'("ebp"),
    48'("esi"), 48'("edi"),
    48'("r8d"), 48'("r9d"), 48'("r10d"), 48'("r11d"), 48'("r12d"), 48'("r13d"),
    48'("r14d"), 48'("r15d"),
    48'("ax"), 48'("cx"), 48'("dx"), 48'("bx"), 48'("sp"), 48'("bp"),
    48'("si"), 48'("di"),
    48'("r8w"), 48'("r9w"), 48'("r10w"), 48'("r11w"), 48'("r12w"), 48'("r13w"),
    48'("r14w"), 48'("r15w"),
    48'("al"), 48'("cl"), 48'("dl"), 48'("bl"), 48'("spl"), 48'("bpl"),
    48'("sil"), 48'("dil"),
    48'("ah"), 48'("ch"), 48'("dh"), 48'("bh"),
    48'("r8b"), 48'("r9b"), 48'("r10b"), 48'("r11b"), 48'("r12b"), 48'("r13b"),
    48'("r14b"), 48'("r15b"),
    48'("byte"), 48'("word"), 48'("dword"), 48'("qword"), 48'("tword"),
    48'("1to2"), 48'("1to4"), 48'("1to8"), 48'("1to16"), 48'("1to32"),
    48'("rel")
  };

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alp(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0b) || (c == 8'h0c);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (is_dig(c)) begin
      v = c - "0";
    end else if ((c >= "a") && (c <= "f")) begin
      v = c - "a" + 8'd10;
    end else begin
      v = c - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic kind_e punct_kind(input logic [7:0] c);
    kind_e k;
    case (c)
      ",":     k = TK_COMMA;
      "[":     k = TK_LBRACKET;
      "]":     k = TK_RBRACKET;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "*":     k = TK_STAR;
      "$":     k = TK_DOLLAR;
      8'h0a:   k = TK_NEWLINE;
      default: k = TK_ERROR;
    endcase
    return k;
  endfunction

  // chars holds the first characters, first in the low byte
  function automatic kw_match_t kw_lookup(input logic [63:0] chars, input logic [7:0] len);
    kw_match_t  r;
    logic [47:0] e;
    logic [7:0]  elen;
    logic        ok;
    r = '0;
    if ((len == 8'd5) && (chars[39:0] == {"D", "R", "O", "W", "Q"})) begin
      r.hit  = 1'b1;
      r.code = QwordCode;
    end
    for (int i = 0; i < NumKeywords; i++) begin
      e    = KwTable[i];
      elen = '0;
      for (int k = 0; k < 6; k++) begin
        if (e[8*k +: 8] != 8'd0) begin
          elen = elen + 8'd1;
        end
      end
      ok = (elen == len);
      for (int k = 0; k < 6; k++) begin
        if ((8'(k) < elen) && (chars[8*k +: 8] != e[8*(int'(elen) - 1 - k) +: 8])) begin
          ok = 1'b0;
        end
      end
      if (ok && !r.hit) begin
        r.hit  = 1'b1;
        r.code = 8'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/tkn_ifs.sv
// Valid/ready channel interfaces for characters and tokens.
interface tkn_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;
  logic       force_word;
  modport source (output valid, char_code, end_of_text, force_word, input ready);
  modport sink (input valid, char_code, end_of_text, force_word, output ready);
endinterface

interface tkn_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [7:0]  keyword_code;
  logic [63:0] number_value;
  logic [63:0] word_chars;
  logic [7:0]  word_length;
  logic        last_of_item;
  modport source (output valid, token_kind, keyword_code, number_value, word_chars,
                  word_length, last_of_item, input ready);
  modport sink (input valid, token_kind, keyword_code, number_value, word_chars,
                word_length, last_of_item, output ready);
endinterface

// File: hw/rtl/tkn_lexer.sv
// Input register, scan state and per-character token logic.
module tkn_lexer import tkn_pkg::*; #(
  parameter int MAX_WORD_CHARS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  item_t      in_item_i,
  input  logic       room_i,
  output logic [1:0] res_cnt_o,
  output token_t     res0_o,
  output token_t     res1_o
);

  localparam int IdxW = $clog2(MAX_WORD_CHARS);

  logic        v_q;
  item_t       item_q;
  mode_e       mode_q, mode_d;
  logic [63:0] acc_q, acc_d;
  logic        sat_q, sat_d;
  logic        stop_q, stop_d;
  logic [7:0]  buf_q [MAX_WORD_CHARS];
  logic [7:0]  buf_d [MAX_WORD_CHARS];
  logic [7:0]  len_q, len_d;
  logic        adv;
  token_t      res [2];
  logic [1:0]  n;

  assign adv        = v_q && room_i;
  assign in_ready_o = !v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      v_q <= 1'b1;
    end else if (adv) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      sat_q  <= 1'b0;
      stop_q <= 1'b0;
      len_q  <= '0;
      for (int i = 0; i < MAX_WORD_CHARS; i++) begin
        buf_q[i] <= '0;
      end
    end else if (adv) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      sat_q  <= sat_d;
      stop_q <= stop_d;
      len_q  <= len_d;
      buf_q  <= buf_d;
    end
  end

  always_comb begin
    logic [7:0]  c;
    logic        goes_on;
    logic        do_acc;
    base_e       base;
    logic [3:0]  digit;
    logic [67:0] wide;
    logic [63:0] chars;
    kw_match_t   kw;
    token_t      pend;
    mode_e       cont_mode;

    c         = item_q.char_code;
    mode_d    = mode_q;
    acc_d     = acc_q;
    sat_d     = sat_q;
    stop_d    = stop_q;
    len_d     = len_q;
    buf_d     = buf_q;
    n         = '0;
    res[0]    = '0;
    res[1]    = '0;
    goes_on   = 1'b0;
    do_acc    = 1'b0;
    base      = BASE_DEC;
    digit     = hex_val(c);
    cont_mode = mode_q;

    chars = '0;
    for (int i = 0; i < MAX_WORD_CHARS; i++) begin
      chars[8*i +: 8] = buf_q[i];
    end
    kw = kw_lookup(chars, len_q);
    pend        = '0;
    pend.chars  = chars;
    pend.length = len_q;
    if (mode_q == MODE_WORD) begin
      pend.kind = kw.hit ? TK_KEYWORD : TK_IDENT;
      pend.code = kw.hit ? kw.code : 8'd0;
    end else begin
      pend.kind  = TK_NUMBER;
      pend.value = sat_q ? '1 : acc_q;
    end

    unique case (mode_q)
      MODE_ZERO: begin
        if (c == "x") begin
          cont_mode = MODE_HEX;
          goes_on   = 1'b1;
        end else if (c == "b") begin
          cont_mode = MODE_BIN;
          goes_on   = 1'b1;
        end else if (is_dig(c)) begin
          cont_mode = MODE_DEC;
          goes_on   = 1'b1;
          do_acc    = 1'b1;
        end
      end
      MODE_DEC: begin
        goes_on = is_dig(c);
        do_acc  = goes_on;
      end
      MODE_HEX: begin
        goes_on = is_hex(c);
        do_acc  = goes_on;
        base    = BASE_HEX;
      end
      MODE_BIN: begin
        goes_on = is_hex(c);
        base    = BASE_BIN;
        stop_d  = stop_q || (goes_on && (c != "0") && (c != "1"));
        do_acc  = goes_on && !stop_d;
      end
      MODE_WORD: begin
        goes_on = is_alp(c) || is_dig(c);
      end
      default: begin
        goes_on = 1'b0;
      end
    endcase

    case (base)
      BASE_HEX: wide = {acc_q, 4'b0};
      BASE_BIN: wide = {3'b0, acc_q, 1'b0};
      default:  wide = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0};
    endcase
    wide = wide + {64'd0, digit};

    if (item_q.end_of_text) begin
      stop_d = 1'b0;
      if (mode_q != MODE_IDLE) begin
        res[0] = pend;
        n      = 2'd1;
      end
      res[n[0]].kind = TK_EOF;
      n      = n + 2'd1;
      mode_d = MODE_IDLE;
      acc_d  = '0;
      sat_d  = 1'b0;
      len_d  = '0;
      for (int i = 0; i < MAX_WORD_CHARS; i++) begin
        buf_d[i] = '0;
      end
    end else if (goes_on) begin
      mode_d = cont_mode;
      if ((c != "x" && c != "b") || mode_q != MODE_ZERO) begin
        if (len_q < 8'(MAX_WORD_CHARS)) begin
          buf_d[len_q[IdxW-1:0]] = c;
        end
        if (len_q != 8'hff) begin
          len_d = len_q + 8'd1;
        end
      end
      if (do_acc && !sat_q) begin
        if (wide[67:64] != 4'd0) begin
          sat_d = 1'b1;
        end else begin
          acc_d = wide[63:0];
        end
      end
    end else begin
      if (mode_q != MODE_IDLE) begin
        res[0] = pend;
        n      = 2'd1;
      end
      mode_d = MODE_IDLE;
      acc_d  = '0;
      sat_d  = 1'b0;
      stop_d = 1'b0;
      len_d  = '0;
      for (int i = 0; i < MAX_WORD_CHARS; i++) begin
        buf_d[i] = '0;
      end
      if (is_blank(c)) begin
        mode_d = MODE_IDLE;
      end else if (is_dig(c) && !item_q.force_word) begin
        if (c == "0") begin
          mode_d = MODE_ZERO;
        end else begin
          mode_d   = MODE_DEC;
          buf_d[0] = c;
          len_d    = 8'd1;
          acc_d    = {60'd0, digit};
        end
      end else if (is_alp(c) || is_dig(c)) begin
        mode_d   = MODE_WORD;
        buf_d[0] = c;
        len_d    = 8'd1;
      end else begin
        res[n[0]].kind = punct_kind(c);
        n = n + 2'd1;
      end
    end

    if (n != 2'd0) begin
      res[n[0] ^ 1'b1].last = 1'b1;
    end
  end

  assign res_cnt_o = adv ? n : 2'd0;
  assign res0_o    = res[0];
  assign res1_o    = res[1];

  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && item_q.end_of_text |=> mode_q == MODE_IDLE)
    else $error("scan not idle after end of text");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_o != 2'd3)
    else $error("more than two tokens from one word");

  a_second_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_o == 2'd2 |-> res1_o.kind != TK_NUMBER && res1_o.kind != TK_IDENT
                          && res1_o.kind != TK_KEYWORD && res0_o.last == 1'b0)
    else $error("second token of a word carries text");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IDLE |-> len_q == 8'd0 && !sat_q && !stop_q)
    else $error("token state left over while idle");

endmodule

// File: hw/rtl/tkn_out_fifo.sv
// Four-entry token queue taking up to two tokens per cycle.
module tkn_out_fifo import tkn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  token_t     push0_i,
  input  token_t     push1_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output token_t     head_o
);

  token_t     mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != 3'd0;
  assign room_o  = cnt_q <= 3'd2;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_cnt_i;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, push_cnt_i} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push1_i;
    end
  end

endmodule

// File: hw/rtl/assembly_text_tokenizer_core.sv
// Top level of the assembly text tokenizer.
//  port     | dir | words
//  char_i   | in  | one character or end of text
//  token_o  | out | one token
// A character enters the input register, is scanned there once the queue has
// room, and its zero to two tokens go to a four-entry queue; one character per cycle
// is sustained while the sink takes every token and characters average at
// most one token each.
// Reset clears the scan state and empties the queue.
// A queue with fewer than two free entries holds the input register and ready falls.
module assembly_text_tokenizer_core import tkn_pkg::*; #(
  parameter int MAX_WORD_CHARS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tkn_char_if.sink    char_i,
  tkn_token_if.source token_o
);

  item_t      item;
  logic       room;
  logic [1:0] res_cnt;
  token_t     res0, res1, head;

  assign item.char_code   = char_i.char_code;
  assign item.end_of_text = char_i.end_of_text;
  assign item.force_word  = char_i.force_word;

  tkn_lexer #(.MAX_WORD_CHARS(MAX_WORD_CHARS)) u_lexer (
    .clk_i,
    .rst_ni,
    .in_valid_i (char_i.valid),
    .in_ready_o (char_i.ready),
    .in_item_i  (item),
    .room_i     (room),
    .res_cnt_o  (res_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  tkn_out_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_cnt_i (res_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .room_o     (room),
    .valid_o    (token_o.valid),
    .ready_i    (token_o.ready),
    .head_o     (head)
  );

  assign token_o.token_kind   = head.kind;
  assign token_o.keyword_code = head.code;
  assign token_o.number_value = head.value;
  assign token_o.word_chars   = head.chars;
  assign token_o.word_length  = head.length;
  assign token_o.last_of_item = head.last;

endmodule
